// File: sv/eight_bit_accumulator_cpu_unit_assert.svh
// assertion macros for the accumulator cpu checker
// no dependencies
`ifndef EIGHT_BIT_ACCUMULATOR_CPU_UNIT_ASSERT_SVH
`define EIGHT_BIT_ACCUMULATOR_CPU_UNIT_ASSERT_SVH
`define ACU_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");
`define ACU_ASSERT_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// File: sv/acu_pkg.sv
// shared constants for the accumulator cpu
// no dependencies
package acu_pkg;
  localparam int PAGE_WORDS = 256;

  localparam logic [2:0] MODE_WR   = 3'd0;
  localparam logic [2:0] MODE_RD   = 3'd1;
  localparam logic [2:0] MODE_EXEC = 3'd2;
  localparam logic [2:0] MODE_IN   = 3'd3;
  localparam logic [2:0] MODE_TAKE = 3'd4;
  localparam logic [2:0] MODE_PC   = 3'd5;
  localparam logic [2:0] MODE_RSV6 = 3'd6;
  localparam logic [2:0] MODE_RSV7 = 3'd7;
endpackage

// File: sv/eight_bit_accumulator_cpu_unit.sv
// accumulator cpu: one request per start, result strobe (done_o) in the last busy cycle
// steps: write/buffer/pc requests go straight to the result, a read adds a memory wait,
//   control, i/o, branch and store run opcode and operand fetch, shifts, loads and alu
//   ops add a data stage (all through one memory port); new requests only when idle
// reset: asynchronous active low clears registers, memory contents undefined
// the receiver cannot stall the result; depends on acu_pkg
module eight_bit_accumulator_cpu_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [2:0] mode_i,
  input  logic [8:0] address_i,
  input  logic [7:0] data_i,
  output logic       done_o,
  output logic [7:0] pc_o,
  output logic [7:0] acc_o,
  output logic [7:0] ix_o,
  output logic [3:0] flags_o,
  output logic [7:0] out_data_o,
  output logic       out_full_o,
  output logic       in_full_o,
  output logic       halted_o,
  output logic       bad_opcode_o,
  output logic [7:0] read_data_o
);
  localparam int AW = $clog2(2 * acu_pkg::PAGE_WORDS);
  localparam logic [2:0] S_IDLE = 3'd0, S_OP = 3'd1, S_ARG = 3'd2, S_DAT = 3'd3,
                         S_DONE = 3'd4, S_WAIT = 3'd5;

  // single port memory, program page then data page
  logic [7:0] mem_q [2*acu_pkg::PAGE_WORDS];
  logic [7:0] rdat_q;
  logic       we;
  logic [AW-1:0] maddr;
  logic [7:0] wdat;

  logic [2:0] st_q, st_d;
  logic [7:0] pc_q, pc_d, acc_q, acc_d, ix_q, ix_d, ob_q, ob_d, ib_q, ib_d;
  logic [3:0] fl_q, fl_d;
  logic ov_q, ov_d, iv_q, iv_d, ht_q, ht_d, bad_q, bad_d;
  logic [7:0] rd_q, rd_d, op_q, op_d, arg_q, arg_d;

  always_ff @(posedge clk_i) begin
    if (we) mem_q[maddr] <= wdat;
    rdat_q <= mem_q[maddr];
  end

  // operand effective address
  logic [AW-1:0] ea;
  logic [7:0] ixd;
  assign ixd = op_q[1] ? ix_q + rdat_q : rdat_q;
  assign ea = {op_q[0], ixd};

  // shifter and branch condition
  logic [7:0] a, r;
  logic c, v, taken;
  always_comb begin
    a = op_q[3] ? ix_q : acc_q;
    unique case (op_q[2:0])
      3'd0: r = {a[7], a[7:1]};
      3'd1, 3'd3: r = {a[6:0], 1'b0};
      3'd2: r = {1'b0, a[7:1]};
      3'd4: r = {fl_q[3], a[7:1]};
      3'd5: r = {a[6:0], fl_q[3]};
      3'd6: r = {a[0], a[7:1]};
      default: r = {a[6:0], a[7]};
    endcase
    // left shifts take carry from the top bit, right shifts from the bottom bit
    c = op_q[0] ? a[7] : a[0];
    v = (op_q[2:0] == 3'd1 || op_q[2:0] == 3'd5) && (a[7] ^ r[7]);
    unique case (op_q[3:0])
      4'h0: taken = 1'b1;
      4'h8: taken = fl_q[2];
      4'h1: taken = !fl_q[0];
      4'h9: taken = fl_q[0];
      4'h2: taken = !fl_q[1];
      4'hA: taken = fl_q[1];
      4'h3: taken = !(fl_q[1] || fl_q[0]);
      4'hB: taken = fl_q[1] || fl_q[0];
      4'h4: taken = !iv_q;
      4'hC: taken = ov_q;
      4'h5: taken = !fl_q[3];
      4'hD: taken = fl_q[3];
      4'h6: taken = fl_q[2] == fl_q[1];
      4'hE: taken = fl_q[2] != fl_q[1];
      4'h7: taken = !((fl_q[2] != fl_q[1]) || fl_q[0]);
      default: taken = (fl_q[2] != fl_q[1]) || fl_q[0];
    endcase
  end

  // operand stage: memory operands come from rdat_q, the others from arg_q
  logic [7:0] opnd;
  logic [7:0] a2, r2;
  logic [8:0] s2;
  logic c2, v2;
  always_comb begin
    opnd = op_q[2] ? rdat_q : arg_q;
    a2 = op_q[3] ? ix_q : acc_q;
    s2 = '0; r2 = opnd; c2 = fl_q[3]; v2 = fl_q[2];
    case (op_q[7:4])
      4'hB, 4'h9: begin
        s2 = {1'b0, a2} + {1'b0, opnd} + {8'd0, op_q[7:4] == 4'h9 && fl_q[3]};
        r2 = s2[7:0]; v2 = (a2[7] ^ r2[7]) & (opnd[7] ^ r2[7]);
        if (op_q[7:4] == 4'h9) c2 = s2[8];
      end
      4'hA, 4'h8, 4'hF: begin
        // bit 8 of the difference is the borrow
        s2 = {1'b0, a2} - {1'b0, opnd} - {8'd0, op_q[7:4] == 4'h8 && fl_q[3]};
        r2 = s2[7:0]; v2 = (a2[7] ^ opnd[7]) & (a2[7] ^ r2[7]);
        if (op_q[7:4] == 4'h8) c2 = s2[8];
      end
      4'hE: begin r2 = a2 & opnd; v2 = 1'b0; end
      4'hD: begin r2 = a2 | opnd; v2 = 1'b0; end
      4'hC: begin r2 = a2 ^ opnd; v2 = 1'b0; end
      default: ;
    endcase
  end

  // sequencer
  logic needarg, needdat, isst;
  always_comb begin
    isst = op_q[7:4] == 4'h7;
    // instructions that need a second byte from the program page
    needarg = op_q == 8'h0A || op_q[7:4] == 4'h3 ||
      ((op_q[7:4] == 4'h6 || op_q[7] || isst) && op_q[2]) ||
      ((op_q[7:4] == 4'h6 || op_q[7]) && op_q[2:1] == 2'b01);
    needdat = (op_q[7:4] == 4'h6 || op_q[7]) && op_q[2];
  end

  always_comb begin
    st_d = st_q; pc_d = pc_q; acc_d = acc_q; ix_d = ix_q; fl_d = fl_q;
    ob_d = ob_q; ov_d = ov_q; ib_d = ib_q; iv_d = iv_q; ht_d = ht_q;
    bad_d = bad_q; rd_d = rd_q; op_d = op_q; arg_d = arg_q;
    we = 1'b0; maddr = address_i[AW-1:0]; wdat = data_i;
    unique case (st_q)
      S_IDLE: if (start_i) begin
        bad_d = 1'b0; rd_d = '0;
        st_d = S_DONE;
        case (mode_i)
          acu_pkg::MODE_WR: we = 1'b1;
          acu_pkg::MODE_RD: st_d = S_WAIT;
          acu_pkg::MODE_EXEC: if (!ht_q) begin
            maddr = {1'b0, pc_q}; pc_d = pc_q + 8'd1; st_d = S_OP;
          end
          acu_pkg::MODE_IN: begin ib_d = data_i; iv_d = 1'b1; end
          acu_pkg::MODE_TAKE: ov_d = 1'b0;
          acu_pkg::MODE_PC: begin pc_d = data_i; ht_d = 1'b0; end
          default: ;
        endcase
      end
      S_WAIT: begin rd_d = rdat_q; st_d = S_DONE; end
      S_OP: begin
        // opcode in rdat_q; request the next program byte
        op_d = rdat_q; maddr = {1'b0, pc_q}; st_d = S_ARG;
      end
      S_ARG: begin
        // rdat_q holds the byte after the opcode
        st_d = S_DONE;
        if (needarg) pc_d = pc_q + 8'd1;
        if (op_q[7:4] == 4'h0) begin
          if (op_q == 8'h0A) begin acc_d = pc_q + 8'd1; pc_d = rdat_q; end
          else if (op_q == 8'h0B) pc_d = acc_q;
          else if (op_q[3:2] == 2'b11) ht_d = 1'b1;
          else if (op_q[3]) bad_d = 1'b1;
        end else if (op_q[7:4] == 4'h1) begin
          if (!op_q[3]) begin ob_d = acc_q; ov_d = 1'b1; end
          else begin acc_d = ib_q; iv_d = 1'b0; end
        end else if (op_q[7:4] == 4'h2) fl_d[3] = op_q[3];
        else if (op_q[7:4] == 4'h3) begin if (taken) pc_d = rdat_q; end
        else if (op_q[7:4] == 4'h4) st_d = S_DAT;
        else if (op_q[7:4] == 4'h5) bad_d = 1'b1;
        else if (isst) begin
          if (!op_q[2]) bad_d = 1'b1;
          else begin
            maddr = ea; we = 1'b1; wdat = op_q[3] ? ix_q : acc_q;
          end
        end else if (needdat) begin
          maddr = ea; st_d = S_DAT;
        end else begin
          // register or immediate operand: held in arg_q for the data stage
          arg_d = op_q[2:1] == 2'b01 ? rdat_q : (op_q[0] ? ix_q : acc_q);
          st_d = S_DAT;
        end
      end
      S_DAT: begin
        st_d = S_DONE;
        if (op_q[7:4] == 4'h4) begin
          fl_d = {c, v, r[7], r == 8'd0};
          if (op_q[3]) ix_d = r; else acc_d = r;
        end else if (op_q[7:4] == 4'h6) begin
          // load leaves the flags alone
          if (op_q[3]) ix_d = opnd; else acc_d = opnd;
        end else if (op_q[7]) begin
          fl_d = {c2, v2, r2[7], r2 == 8'd0};
          // compare only sets the flags
          if (op_q[7:4] != 4'hF) begin
            if (op_q[3]) ix_d = r2; else acc_d = r2;
          end
        end
      end
      // result cycle, then back to idle
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; pc_q <= '0; acc_q <= '0; ix_q <= '0; fl_q <= '0;
      ob_q <= '0; ov_q <= 1'b0; ib_q <= '0; iv_q <= 1'b0; ht_q <= 1'b0;
      bad_q <= 1'b0; rd_q <= '0; op_q <= '0; arg_q <= '0;
    end else begin
      st_q <= st_d; pc_q <= pc_d; ob_q <= ob_d; ov_q <= ov_d; ib_q <= ib_d;
      iv_q <= iv_d; ht_q <= ht_d; bad_q <= bad_d;
      rd_q <= rd_d; op_q <= op_d; arg_q <= arg_d;
      acc_q <= acc_d; ix_q <= ix_d; fl_q <= fl_d;
    end
  end

  assign busy_o = st_q != S_IDLE;
  assign done_o = st_q == S_DONE;
  assign pc_o = pc_q;
  assign acc_o = acc_q;
  assign ix_o = ix_q;
  assign flags_o = fl_q;
  assign out_data_o = ob_q;
  assign out_full_o = ov_q;
  assign in_full_o = iv_q;
  assign halted_o = ht_q;
  assign bad_opcode_o = bad_q;
  assign read_data_o = rd_q;
endmodule

// File: sv/acu_checker.sv
// port level checks for the accumulator cpu
// depends on eight_bit_accumulator_cpu_unit_assert.svh
`include "eight_bit_accumulator_cpu_unit_assert.svh"
module acu_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o,
  input logic bad_opcode_o,
  input logic [7:0] read_data_o
);
  `ACU_ASSERT_NXT(a_busy_after_start, clk_i, rst_ni, start_i && !busy_o, busy_o)
  `ACU_ASSERT_NXT(a_idle_after_done, clk_i, rst_ni, done_o, !busy_o)
  `ACU_ASSERT_IMP(a_done_in_busy, clk_i, rst_ni, done_o, busy_o)
  `ACU_ASSERT_NXT(a_single_strobe, clk_i, rst_ni, done_o, !done_o)
  // a read never executes, so read data and a bad opcode cannot coexist
  `ACU_ASSERT_IMP(a_rd_or_bad, clk_i, rst_ni, bad_opcode_o, read_data_o == 8'd0)
endmodule

bind eight_bit_accumulator_cpu_unit acu_checker u_acu_checker (.*);
